/* sv/mdhc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and the log2 fraction table for the dB heat colormap.
// No dependencies; the log2, dB, color and top-level files refer to this package by scoped names.

package mdhc_pkg;

	// 20*log10(2) in Q16: dB per octave of magnitude.
	localparam logic signed [19:0] DB_PER_OCT_Q16 = 20'sd394566;

	// Upper clamp of the window offset: 60 dB in Q.32.
	localparam int Y_W = 38;
	localparam logic [Y_W-1:0] Y_MAX = 38'd60 << 32;

	// Window offset shifted down by 16 bits, and the Q16 window position.
	localparam int Q_W = 22;
	localparam int U_W = 19;

	// floor(2^26 / 15): reciprocal used to divide by 15.
	localparam int RECIP_W = 23;
	localparam logic [RECIP_W-1:0] RECIP_15 = 23'd4473924;
	localparam int RECIP_SHIFT = 26;
	localparam int PROD_W = Q_W + RECIP_W;

	// Gradient segment codes.
	localparam logic [2:0] SEG_BLACK_BLUE   = 3'd0;
	localparam logic [2:0] SEG_BLUE_CYAN    = 3'd1;
	localparam logic [2:0] SEG_CYAN_YELLOW  = 3'd2;
	localparam logic [2:0] SEG_YELLOW_WHITE = 3'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// log2(1 + i/16) in Q16 for i = 0..16.
	function automatic logic [16:0] log2_tab(input logic [4:0] idx);
		logic [16:0] val;
		unique case (idx)
			5'd0:    val = 17'd0;
			5'd1:    val = 17'd5732;
			5'd2:    val = 17'd11136;
			5'd3:    val = 17'd16248;
			5'd4:    val = 17'd21098;
			5'd5:    val = 17'd25711;
			5'd6:    val = 17'd30109;
			5'd7:    val = 17'd34312;
			5'd8:    val = 17'd38336;
			5'd9:    val = 17'd42196;
			5'd10:   val = 17'd45904;
			5'd11:   val = 17'd49472;
			5'd12:   val = 17'd52911;
			5'd13:   val = 17'd56229;
			5'd14:   val = 17'd59434;
			5'd15:   val = 17'd62534;
			5'd16:   val = 17'd65536;
			default: val = 17'd0;
		endcase
		return val;
	endfunction

endpackage

/* sv/mdhc_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: magnitude input and RGB result.
// Does not depend on mdhc_pkg; the color channel carries plain 8-bit red, green and blue fields.

interface mdhc_mag_if #(
	parameter int MAG_WIDTH = 32
);
	logic                 valid;
	logic                 ready;
	logic [MAG_WIDTH-1:0] magnitude;

	modport source (output valid, output magnitude, input ready);
	modport sink (input valid, input magnitude, output ready);
endinterface

interface mdhc_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

/* sv/mdhc_log2.sv */
`timescale 1ns / 1ps
// Three-stage log2 unit: leading-one search, mantissa extraction, table interpolation.
// Depends on mdhc_pkg for the log2 fraction table.

module mdhc_log2 #(
	parameter int MAG_WIDTH     = 32,
	parameter int MAG_FRAC_BITS = 16,
	localparam int PW = $clog2(MAG_WIDTH),
	localparam int EW = $clog2(MAG_WIDTH + MAG_FRAC_BITS) + 1,
	localparam int LW = EW + 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MAG_WIDTH-1:0] mag,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [LW-1:0] lq,
	output logic                 nz
);

	logic                 en1, en2, en3;
	logic                 v_s1, v_s2, v_s3;
	logic [PW-1:0]        lead;
	logic [MAG_WIDTH-1:0] m_s1;
	logic [PW-1:0]        p_s1;
	logic                 nz_s1, nz_s2, nz_s3;
	logic [MAG_WIDTH+15:0] ext;
	logic [15:0]          below;
	logic signed [EW-1:0] e_next, e_s2;
	logic [3:0]           idx_s2;
	logic [11:0]          w_s2;
	logic [16:0]          t0, t1;
	logic [12:0]          diff;
	logic [24:0]          interp;
	logic [16:0]          frac;
	logic signed [LW-1:0] lq_next, lq_s3;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// Highest set bit wins.
	always_comb begin
		lead = '0;
		for (int k = 0; k < MAG_WIDTH; k++) begin
			if (mag[k]) begin
				lead = PW'(k);
			end
		end
	end

	// Zero fill on the right so the 16 bits below the leading one always exist.
	assign ext    = {m_s1, 16'h0000};
	assign below  = ext[p_s1 +: 16];
	assign e_next = $signed({{(EW-PW){1'b0}}, p_s1}) - EW'(MAG_FRAC_BITS);

	assign t0      = mdhc_pkg::log2_tab({1'b0, idx_s2});
	assign t1      = mdhc_pkg::log2_tab(5'({1'b0, idx_s2}) + 5'd1);
	assign diff    = 13'(t1 - t0);
	assign interp  = 25'(diff) * 25'(w_s2);
	assign frac    = t0 + 17'(interp[24:12]);
	assign lq_next = LW'($signed({e_s2, 16'h0000})) + $signed({{(LW-17){1'b0}}, frac});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			m_s1  <= mag;
			p_s1  <= lead;
			nz_s1 <= |mag;
		end
		if (en2 && v_s1) begin
			idx_s2 <= below[15:12];
			w_s2   <= below[11:0];
			e_s2   <= e_next;
			nz_s2  <= nz_s1;
		end
		if (en3 && v_s2) begin
			lq_s3 <= lq_next;
			nz_s3 <= nz_s2;
		end
	end

	assign out_valid = v_s3;
	assign lq        = lq_s3;
	assign nz        = nz_s3;

endmodule

/* sv/mdhc_db.sv */
`timescale 1ns / 1ps
// Two-stage decibel scaler: log2 times 20*log10(2), then floor offset and clamp.
// Depends on mdhc_pkg for the scale factor and the window limit.

module mdhc_db #(
	parameter int MAG_WIDTH     = 32,
	parameter int MAG_FRAC_BITS = 16,
	localparam int EW = $clog2(MAG_WIDTH + MAG_FRAC_BITS) + 1,
	localparam int LW = EW + 17
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [LW-1:0]      lq,
	input  logic                      nz_in,
	input  logic signed [7:0]         floor_db,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [mdhc_pkg::Q_W-1:0]  q,
	output logic                      nz
);

	localparam int DW = LW + 20;
	localparam int YW = DW + 1;

	logic                        en4, en5;
	logic                        v_s4, v_s5;
	logic signed [DW-1:0]        dq_next, dq_s4;
	logic                        nz_s4, nz_s5;
	logic signed [YW-1:0]        y_raw;
	logic signed [YW-1:0]        y_lim;
	logic [mdhc_pkg::Y_W-1:0]    y_cl;
	logic [mdhc_pkg::Q_W-1:0]    q_s5;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign in_ready = en4;

	assign dq_next = DW'(lq) * DW'(mdhc_pkg::DB_PER_OCT_Q16);

	assign y_raw = YW'(dq_s4) - YW'($signed({floor_db, 32'h0000_0000}));
	assign y_lim = $signed({{(YW-mdhc_pkg::Y_W){1'b0}}, mdhc_pkg::Y_MAX});

	always_comb begin
		priority if (y_raw < 0) begin
			y_cl = '0;
		end else if (y_raw > y_lim) begin
			y_cl = mdhc_pkg::Y_MAX;
		end else begin
			y_cl = y_raw[mdhc_pkg::Y_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en4) v_s4 <= in_valid;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && in_valid) begin
			dq_s4 <= dq_next;
			nz_s4 <= nz_in;
		end
		if (en5 && v_s4) begin
			q_s5  <= y_cl[mdhc_pkg::Y_W-1:16];
			nz_s5 <= nz_s4;
		end
	end

	assign out_valid = v_s5;
	assign q         = q_s5;
	assign nz        = nz_s5;

endmodule

/* sv/mdhc_color.sv */
`timescale 1ns / 1ps
// Three-stage color stage: divide by 15 through a reciprocal, correct, map to RGB.
// Depends on mdhc_pkg for the reciprocal, segment codes and the color type.

module mdhc_color (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [mdhc_pkg::Q_W-1:0] q,
	input  logic                     nz_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output mdhc_pkg::rgb_t           rgb
);

	logic                          en6, en7, en8;
	logic                          v_s6, v_s7, v_s8;
	logic [mdhc_pkg::PROD_W-1:0]   prod;
	logic [mdhc_pkg::U_W-1:0]      u0_s6, u_s7;
	logic [mdhc_pkg::Q_W-1:0]      q_s6;
	logic                          nz_s6, nz_s7;
	logic [mdhc_pkg::Q_W-1:0]      rem;
	logic [mdhc_pkg::U_W-1:0]      u_next;
	logic [2:0]                    seg;
	logic [15:0]                   f;
	logic [23:0]                   up_p;
	logic [16:0]                   inv_f;
	logic [24:0]                   dn_p;
	logic [7:0]                    up, dn;
	mdhc_pkg::rgb_t                rgb_next, rgb_s8;

	assign en8      = !v_s8 || out_ready;
	assign en7      = !v_s7 || en8;
	assign en6      = !v_s6 || en7;
	assign in_ready = en6;

	assign prod = mdhc_pkg::PROD_W'(q) * mdhc_pkg::PROD_W'(mdhc_pkg::RECIP_15);

	// The truncated reciprocal undershoots by at most one, so one compare fixes it.
	assign rem    = q_s6 - mdhc_pkg::Q_W'({u0_s6, 4'h0}) + mdhc_pkg::Q_W'(u0_s6);
	assign u_next = (rem >= mdhc_pkg::Q_W'(15)) ? u0_s6 + 1'b1 : u0_s6;

	assign seg   = u_s7[mdhc_pkg::U_W-1:16];
	assign f     = u_s7[15:0];
	assign up_p  = {f, 8'h00} - 24'(f);
	assign inv_f = 17'h10000 - 17'(f);
	assign dn_p  = {inv_f, 8'h00} - 25'(inv_f);
	assign up    = up_p[23:16];
	assign dn    = dn_p[23:16];

	always_comb begin
		unique case (seg)
			mdhc_pkg::SEG_BLACK_BLUE:   rgb_next = '{red: 8'd0,   green: 8'd0,   blue: up};
			mdhc_pkg::SEG_BLUE_CYAN:    rgb_next = '{red: 8'd0,   green: up,     blue: 8'd255};
			mdhc_pkg::SEG_CYAN_YELLOW:  rgb_next = '{red: up,     green: 8'd255, blue: dn};
			mdhc_pkg::SEG_YELLOW_WHITE: rgb_next = '{red: 8'd255, green: 8'd255, blue: up};
			default:                    rgb_next = '{red: 8'd255, green: 8'd255, blue: 8'd255};
		endcase
		if (!nz_s7) begin
			rgb_next = '{red: 8'd0, green: 8'd0, blue: 8'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en6) v_s6 <= in_valid;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en6 && in_valid) begin
			u0_s6 <= prod[mdhc_pkg::PROD_W-1:mdhc_pkg::RECIP_SHIFT];
			q_s6  <= q;
			nz_s6 <= nz_in;
		end
		if (en7 && v_s6) begin
			u_s7  <= u_next;
			nz_s7 <= nz_s6;
		end
		if (en8 && v_s7) begin
			rgb_s8 <= rgb_next;
		end
	end

	assign out_valid = v_s8;
	assign rgb       = rgb_s8;

endmodule

/* sv/magnitude_db_heat_colormap_unit.sv */
`timescale 1ns / 1ps
// Top level of the dB heat colormap: magnitude in, RGB out, floor register.
// Depends on mdhc_pkg, mdhc_ifs, mdhc_log2, mdhc_db and mdhc_color.
//
//   channel   direction  payload                      handshake
//   mag_in    in         magnitude [MAG_WIDTH-1:0]    valid / ready
//   rgb_out   out        red, green, blue [7:0]       valid / ready
//   cfg       in         cfg_wdata [7:0] (floor_db)   cfg_we, no wait
//
// One item per clock unless the output stalls; eight pipeline registers in all,
// the last of which is the output register.
// Each stage holds its own valid bit and advances when empty or when the next
// stage advances, so bubbles close up under backpressure and nothing is dropped.
// Reset clears all valid bits and loads floor_db with -60.

module magnitude_db_heat_colormap_unit #(
	parameter int MAG_WIDTH     = 32,
	parameter int MAG_FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	mdhc_mag_if.sink         mag_in,
	mdhc_rgb_if.source       rgb_out,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata
);

	localparam int EW = $clog2(MAG_WIDTH + MAG_FRAC_BITS) + 1;
	localparam int LW = EW + 17;

	logic signed [7:0]         floor_db_q;
	logic                      lg_valid, lg_ready;
	logic signed [LW-1:0]      lg_lq;
	logic                      lg_nz;
	logic                      db_valid, db_ready;
	logic [mdhc_pkg::Q_W-1:0]  db_q;
	logic                      db_nz;
	logic [MAG_WIDTH-1:0]      mag;
	mdhc_pkg::rgb_t            rgb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_db_q <= -8'sd60;
		end else if (cfg_we) begin
			floor_db_q <= $signed(cfg_wdata);
		end
	end

	assign mag = mag_in.magnitude;

	mdhc_log2 #(
		.MAG_WIDTH     (MAG_WIDTH),
		.MAG_FRAC_BITS (MAG_FRAC_BITS)
	) u_log2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mag_in.valid),
		.in_ready  (mag_in.ready),
		.mag       (mag),
		.out_valid (lg_valid),
		.out_ready (lg_ready),
		.lq        (lg_lq),
		.nz        (lg_nz)
	);

	mdhc_db #(
		.MAG_WIDTH     (MAG_WIDTH),
		.MAG_FRAC_BITS (MAG_FRAC_BITS)
	) u_db (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lg_valid),
		.in_ready  (lg_ready),
		.lq        (lg_lq),
		.nz_in     (lg_nz),
		.floor_db  (floor_db_q),
		.out_valid (db_valid),
		.out_ready (db_ready),
		.q         (db_q),
		.nz        (db_nz)
	);

	mdhc_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (db_valid),
		.in_ready  (db_ready),
		.q         (db_q),
		.nz_in     (db_nz),
		.out_valid (rgb_out.valid),
		.out_ready (rgb_out.ready),
		.rgb       (rgb)
	);

	assign rgb_out.red   = rgb.red;
	assign rgb_out.green = rgb.green;
	assign rgb_out.blue  = rgb.blue;

endmodule

/* sv/mdhc_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the dB heat colormap, bound to the top level.
// Depends only on the top level's ports.

module mdhc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	// A result held back by the sink stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({red, green, blue}))
		else $error("stalled result changed or vanished");

	// With the output side draining, every stage advances, so input is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is ready");

	// Any red at all only appears once green has saturated.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && red != 8'd0 |-> green == 8'd255)
		else $error("red without full green");

	// A partial green belongs to the blue-cyan segment only.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && green != 8'd0 && green != 8'd255 |-> red == 8'd0 && blue == 8'd255)
		else $error("partial green outside the blue-cyan segment");

	// The first edge after reset release shows an empty pipeline.
	assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind magnitude_db_heat_colormap_unit mdhc_checker u_mdhc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (mag_in.ready),
	.out_valid (rgb_out.valid),
	.out_ready (rgb_out.ready),
	.red       (rgb_out.red),
	.green     (rgb_out.green),
	.blue      (rgb_out.blue)
);
